/* rtl/core/circular_list_insert_remove_unit_defines.svh */
// Assertion macros shared by the circular list insert/remove unit.
// Taken in by `include in the files that carry concurrent checks.
`ifndef CIRCULAR_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH
`define CIRCULAR_LIST_INSERT_REMOVE_UNIT_DEFINES_SVH

// Condition and consequence in the same cycle.
`define CLIR_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("clir: same-cycle check failed");

// Consequence in the cycle after the condition.
`define CLIR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("clir: next-cycle check failed");

`endif

/* rtl/core/clir_pkg.sv */
// Shared types and constants of the circular list insert/remove unit.
// No dependencies.
`timescale 1ns / 1ps

package clir_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 7;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;

   localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
   localparam logic [OP_W-1:0] OP_PREPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TAKE,
      S_WALK,
      S_FETCH,
      S_PATCH
   } state_type;

endpackage

/* rtl/core/clir_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module clir_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/circular_list_insert_remove_unit.sv */
// Circular list insert/remove unit: control, pointers and the two slot RAMs.
// Depends on clir_pkg, clir_ram and circular_list_insert_remove_unit_defines.svh.
// Append/prepend: IDLE accepts, then TAKE pops the free head (one link RAM read) and returns.
// Remove: WALK visits the entries of the link walk in turn, then PATCH relinks a link or FETCH
// takes the new front value. Full, empty and unused ops are answered straight from IDLE.
// The result strobe is registered and comes in the cycle after the last work state; the receiver cannot stall.
// Reset is synchronous; the initial free chain comes from a fill mark.
`timescale 1ns / 1ps
`include "circular_list_insert_remove_unit_defines.svh"

module circular_list_insert_remove_unit #(
   parameter int CAPACITY = clir_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [clir_pkg::OP_W-1:0]           req_operation,
   input  logic signed [clir_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic [clir_pkg::STATUS_W-1:0]       rsp_status,
   output logic [clir_pkg::COUNT_W-1:0]        rsp_count,
   output logic signed [clir_pkg::DATA_W-1:0]  rsp_front_value,
   output logic signed [clir_pkg::DATA_W-1:0]  rsp_back_value
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   clir_pkg::state_type state_ff, state_in;

   logic [clir_pkg::OP_W-1:0]          op_ff, op_in;
   logic signed [clir_pkg::DATA_W-1:0] key_ff, key_in;
   logic [IW-1:0]                      front_ff, front_in;
   logic [IW-1:0]                      back_ff, back_in;
   logic [IW-1:0]                      free_ff, free_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [CW-1:0]                      hwm_ff, hwm_in;
   logic signed [clir_pkg::DATA_W-1:0] front_val_ff, front_val_in;
   logic signed [clir_pkg::DATA_W-1:0] back_val_ff, back_val_in;
   logic [IW-1:0]                      cur_ff, cur_in;
   logic [IW-1:0]                      prev_ff, prev_in;
   logic signed [clir_pkg::DATA_W-1:0] prev_val_ff, prev_val_in;
   logic [CW-1:0]                      step_ff, step_in;
   logic [IW-1:0]                      nxt_ff, nxt_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [clir_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [clir_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic signed [clir_pkg::DATA_W-1:0] rsp_front_ff, rsp_back_ff;

   // RAM ports
   logic [IW-1:0]                 rd_addr;
   logic                          val_we;
   logic [IW-1:0]                 val_waddr;
   logic [clir_pkg::DATA_W-1:0]   val_wdata;
   logic [clir_pkg::DATA_W-1:0]   val_rdata;
   logic                          link_we;
   logic [IW-1:0]                 link_waddr;
   logic [IW-1:0]                 link_wdata;
   logic [IW-1:0]                 link_rdata;

   // Slots at or above the fill mark were never written: their link is the next slot.
   logic          fresh;
   logic [IW-1:0] fresh_next;

   assign fresh      = (hwm_ff != CW'(CAPACITY)) && (free_ff == hwm_ff[IW-1:0]);
   assign fresh_next = (hwm_ff[IW-1:0] == IW'(CAPACITY - 1)) ? '0 : hwm_ff[IW-1:0] + IW'(1);

   clir_ram #(
      .WIDTH (clir_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_waddr),
      .wdata (val_wdata),
      .raddr (rd_addr),
      .rdata (val_rdata)
   );

   clir_ram #(
      .WIDTH (IW),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (rd_addr),
      .rdata (link_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clir_pkg::S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         hwm_ff       <= '0;
         front_val_ff <= '0;
         back_val_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         hwm_ff       <= hwm_in;
         front_val_ff <= front_val_in;
         back_val_ff  <= back_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_val_ff   <= prev_val_in;
      step_ff       <= step_in;
      nxt_ff        <= nxt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= (clir_pkg::COUNT_W)'(count_in);
      rsp_front_ff  <= front_val_in;
      rsp_back_ff   <= back_val_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      hwm_in        = hwm_ff;
      front_val_in  = front_val_ff;
      back_val_in   = back_val_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_val_in   = prev_val_ff;
      step_in       = step_ff;
      nxt_in        = nxt_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = clir_pkg::STATUS_OK;
      rd_addr       = free_ff;
      val_we        = 1'b0;
      val_waddr     = free_ff;
      val_wdata     = key_ff;
      link_we       = 1'b0;
      link_waddr    = free_ff;
      link_wdata    = free_ff;

      case (state_ff)
         clir_pkg::S_IDLE: begin
            if (start) begin
               op_in  = req_operation;
               key_in = req_value;
               if (req_operation inside {clir_pkg::OP_APPEND, clir_pkg::OP_PREPEND}) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = clir_pkg::STATUS_FULL;
                  end else begin
                     state_in = clir_pkg::S_TAKE;
                  end
               end else if (req_operation == clir_pkg::OP_REMOVE) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = clir_pkg::STATUS_EMPTY;
                  end else begin
                     rd_addr  = front_ff;
                     cur_in   = front_ff;
                     prev_in  = front_ff;
                     step_in  = '0;
                     state_in = clir_pkg::S_WALK;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end

         clir_pkg::S_TAKE: begin
            // Pop the free head; the link RAM holds its successor unless it is fresh.
            free_in   = fresh ? fresh_next : link_rdata;
            hwm_in    = fresh ? hwm_ff + CW'(1) : hwm_ff;
            val_we    = 1'b1;
            val_waddr = free_ff;
            val_wdata = key_ff;
            if (count_ff == '0) begin
               front_in     = free_ff;
               back_in      = free_ff;
               front_val_in = key_ff;
               back_val_in  = key_ff;
            end else if (op_ff == clir_pkg::OP_PREPEND) begin
               link_we      = 1'b1;
               link_waddr   = free_ff;
               link_wdata   = front_ff;
               front_in     = free_ff;
               front_val_in = key_ff;
            end else begin
               link_we     = 1'b1;
               link_waddr  = back_ff;
               link_wdata  = free_ff;
               back_in     = free_ff;
               back_val_in = key_ff;
            end
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            state_in     = clir_pkg::S_IDLE;
         end

         clir_pkg::S_WALK: begin
            // Read data belongs to cur; the link output addresses the next step directly.
            rd_addr = link_rdata;
            if (val_rdata == key_ff) begin
               link_we    = 1'b1;
               link_waddr = cur_ff;
               link_wdata = free_ff;
               free_in    = cur_ff;
               count_in   = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  front_in     = '0;
                  back_in      = '0;
                  front_val_in = '0;
                  back_val_in  = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = clir_pkg::S_IDLE;
               end else if (step_ff == '0) begin
                  // New front value comes out of the RAM next cycle.
                  front_in = link_rdata;
                  state_in = clir_pkg::S_FETCH;
               end else begin
                  nxt_in = link_rdata;
                  if (cur_ff == back_ff) begin
                     back_in     = prev_ff;
                     back_val_in = prev_val_ff;
                  end
                  state_in = clir_pkg::S_PATCH;
               end
            end else if (step_ff + CW'(1) == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = clir_pkg::STATUS_NOTFOUND;
               state_in      = clir_pkg::S_IDLE;
            end else begin
               prev_in     = cur_ff;
               prev_val_in = val_rdata;
               cur_in      = link_rdata;
               step_in     = step_ff + CW'(1);
            end
         end

         clir_pkg::S_FETCH: begin
            front_val_in = val_rdata;
            rsp_valid_in = 1'b1;
            state_in     = clir_pkg::S_IDLE;
         end

         clir_pkg::S_PATCH: begin
            // Bypass the removed entry.
            link_we      = 1'b1;
            link_waddr   = prev_ff;
            link_wdata   = nxt_ff;
            rsp_valid_in = 1'b1;
            state_in     = clir_pkg::S_IDLE;
         end

         default: begin
            state_in = clir_pkg::S_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != clir_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;

   `CLIR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `CLIR_ASSERT_SAME(a_idle_no_write, clock, reset, state_ff == clir_pkg::S_IDLE, !link_we && !val_we)
   `CLIR_ASSERT_SAME(a_empty_zero, clock, reset, count_ff == '0, front_val_ff == '0 && back_val_ff == '0)
   `CLIR_ASSERT_SAME(a_walk_step, clock, reset, state_ff == clir_pkg::S_WALK, step_ff < count_ff)
   `CLIR_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)

endmodule

/* tb/clir_checker.sv */
// Checker for the circular list insert/remove unit: tracks accepted requests, keeps
// its own linked-slot model of the list, and compares every strobed result in order.
// Depends on clir_pkg.
`timescale 1ns / 1ps

module clir_checker #(
   parameter int CAPACITY = clir_pkg::DEF_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [clir_pkg::OP_W-1:0]           req_operation,
   input  logic signed [clir_pkg::DATA_W-1:0]  req_value,
   input  logic                                rsp_valid,
   input  logic [clir_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [clir_pkg::COUNT_W-1:0]        rsp_count,
   input  logic signed [clir_pkg::DATA_W-1:0]  rsp_front_value,
   input  logic signed [clir_pkg::DATA_W-1:0]  rsp_back_value,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  results_checked,
   output int                                  full_seen,
   output int                                  empty_seen,
   output int                                  miss_seen
);

   localparam int SLOT_W = $clog2(CAPACITY);

   typedef logic [SLOT_W-1:0] slot_idx_type;

   typedef struct packed {
      logic [clir_pkg::STATUS_W-1:0]      status;
      logic [clir_pkg::COUNT_W-1:0]       count;
      logic signed [clir_pkg::DATA_W-1:0] front_value;
      logic signed [clir_pkg::DATA_W-1:0] back_value;
   } list_result_type;

   logic signed [clir_pkg::DATA_W-1:0] slot_data [CAPACITY];
   slot_idx_type                       slot_next [CAPACITY];
   slot_idx_type                       head_slot;
   slot_idx_type                       tail_slot;
   slot_idx_type                       free_head;
   int                                 entries;

   list_result_type expected_results [$];
   int fails;
   int checked;
   int n_full;
   int n_empty;
   int n_miss;

   task automatic clear_list();
      for (int i = 0; i < CAPACITY; i++) begin
         slot_data[i] = '0;
         slot_next[i] = slot_idx_type'((i + 1) % CAPACITY);
      end
      head_slot = '0;
      tail_slot = '0;
      free_head = '0;
      entries   = 0;
   endtask

   function automatic logic [clir_pkg::STATUS_W-1:0] link_new_entry(
      input logic signed [clir_pkg::DATA_W-1:0] v,
      input logic at_front
   );
      slot_idx_type s;
      if (entries >= CAPACITY) return clir_pkg::STATUS_FULL;
      s = free_head;
      free_head = slot_next[s];
      slot_data[s] = v;
      if (entries == 0) begin
         head_slot = s;
         tail_slot = s;
      end else if (at_front) begin
         slot_next[s] = head_slot;
         head_slot = s;
      end else begin
         slot_next[tail_slot] = s;
         tail_slot = s;
      end
      entries++;
      return clir_pkg::STATUS_OK;
   endfunction

   function automatic logic [clir_pkg::STATUS_W-1:0] unlink_first_match(
      input logic signed [clir_pkg::DATA_W-1:0] key
   );
      slot_idx_type cur;
      slot_idx_type prev;
      slot_idx_type nxt;
      if (entries == 0) return clir_pkg::STATUS_EMPTY;
      cur  = head_slot;
      prev = cur;
      for (int i = 0; i < entries; i++) begin
         if (slot_data[cur] == key) begin
            nxt = slot_next[cur];
            if (i == 0) head_slot = nxt;
            else slot_next[prev] = nxt;
            // removing the tail makes its predecessor the new tail
            if (cur == tail_slot) tail_slot = prev;
            slot_next[cur] = free_head;
            free_head = cur;
            entries--;
            if (entries == 0) begin
               head_slot = '0;
               tail_slot = '0;
            end
            return clir_pkg::STATUS_OK;
         end
         prev = cur;
         cur  = slot_next[cur];
      end
      return clir_pkg::STATUS_NOTFOUND;
   endfunction

   function automatic list_result_type apply_request(
      input logic [clir_pkg::OP_W-1:0]          op,
      input logic signed [clir_pkg::DATA_W-1:0] v
   );
      list_result_type r;
      r.status = clir_pkg::STATUS_OK;
      case (op)
         clir_pkg::OP_APPEND:  r.status = link_new_entry(v, 1'b0);
         clir_pkg::OP_PREPEND: r.status = link_new_entry(v, 1'b1);
         clir_pkg::OP_REMOVE:  r.status = unlink_first_match(v);
         default: ;
      endcase
      r.count = (clir_pkg::COUNT_W)'(entries);
      if (entries == 0) begin
         r.front_value = '0;
         r.back_value  = '0;
      end else begin
         r.front_value = slot_data[head_slot];
         r.back_value  = slot_data[tail_slot];
      end
      return r;
   endfunction

   task automatic report_mismatch(
      input string                       field,
      input logic [clir_pkg::DATA_W-1:0] want_v,
      input logic [clir_pkg::DATA_W-1:0] got_v
   );
      $display("%0t: result %0d %s mismatch: expected %h, got %h",
               $time, checked, field, want_v, got_v);
      fails++;
   endtask

   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (reset) begin
         clear_list();
         expected_results.delete();
         fails   = 0;
         checked = 0;
         n_full  = 0;
         n_empty = 0;
         n_miss  = 0;
      end else begin
         // compare first: a strobe at this edge belongs to an earlier request
         if (rsp_valid) begin
            got = '{rsp_status, rsp_count, rsp_front_value, rsp_back_value};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, status %h count %h front %h back %h",
                        $time, rsp_status, rsp_count, rsp_front_value, rsp_back_value);
               fails++;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", (clir_pkg::DATA_W)'(want.status),
                                  (clir_pkg::DATA_W)'(got.status));
               if (got.count !== want.count)
                  report_mismatch("count", (clir_pkg::DATA_W)'(want.count),
                                  (clir_pkg::DATA_W)'(got.count));
               if (got.front_value !== want.front_value)
                  report_mismatch("front_value", want.front_value, got.front_value);
               if (got.back_value !== want.back_value)
                  report_mismatch("back_value", want.back_value, got.back_value);
               checked++;
            end
         end
         if (start && !busy) begin
            want = apply_request(req_operation, req_value);
            case (want.status)
               clir_pkg::STATUS_FULL:     n_full++;
               clir_pkg::STATUS_EMPTY:    n_empty++;
               clir_pkg::STATUS_NOTFOUND: n_miss++;
               default: ;
            endcase
            expected_results.push_back(want);
         end
      end
      fail_count      <= fails;
      pending         <= expected_results.size();
      results_checked <= checked;
      full_seen       <= n_full;
      empty_seen      <= n_empty;
      miss_seen       <= n_miss;
   end

endmodule

/* tb/testbench.sv */
// Top of the list unit regression: clock, reset, request stimulus and the verdict.
// Depends on clir_pkg, circular_list_insert_remove_unit and clir_checker.
`timescale 1ns / 1ps

module testbench;

   localparam int                        CAPACITY     = clir_pkg::DEF_CAPACITY;
   localparam int                        RANDOM_ITEMS = 1630;
   localparam int                        CYCLE_LIMIT  = 1_000_000;
   localparam logic [clir_pkg::OP_W-1:0] OP_UNUSED    = 2'd3;

   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED
   } traffic_mode_type;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [clir_pkg::OP_W-1:0]          req_operation;
   logic signed [clir_pkg::DATA_W-1:0] req_value;
   logic                               rsp_valid;
   logic [clir_pkg::STATUS_W-1:0]      rsp_status;
   logic [clir_pkg::COUNT_W-1:0]       rsp_count;
   logic signed [clir_pkg::DATA_W-1:0] rsp_front_value;
   logic signed [clir_pkg::DATA_W-1:0] rsp_back_value;

   int fail_count;
   int pending;
   int results_checked;
   int full_seen;
   int empty_seen;
   int miss_seen;

   int                                 cycle_count = 0;
   int                                 burst_left;
   int                                 op_tally [4];
   logic signed [clir_pkg::DATA_W-1:0] sent_values [$];

   circular_list_insert_remove_unit #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value (rsp_back_value)
   );

   clir_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value (rsp_back_value),
      .fail_count     (fail_count),
      .pending        (pending),
      .results_checked(results_checked),
      .full_seen      (full_seen),
      .empty_seen     (empty_seen),
      .miss_seen      (miss_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Hold the request until it is taken, then either go straight on or idle a while.
   task automatic issue_request(
      input logic [clir_pkg::OP_W-1:0]          op,
      input logic signed [clir_pkg::DATA_W-1:0] v
   );
      req_operation <= op;
      req_value     <= v;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      op_tally[op]++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   // Four draws in ten come from a small pool so duplicates and key hits are common.
   function automatic logic signed [clir_pkg::DATA_W-1:0] pick_value();
      logic signed [clir_pkg::DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = '0;
               default: v = '1;
            endcase
         end
         1, 2, 3, 4: v = $signed($urandom_range(0, 7)) - 3;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic issue_random(input traffic_mode_type mode);
      int                                 roll;
      int                                 pick;
      logic [clir_pkg::OP_W-1:0]          op;
      logic signed [clir_pkg::DATA_W-1:0] v;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (roll < 43) op = clir_pkg::OP_APPEND;
            else if (roll < 86) op = clir_pkg::OP_PREPEND;
            else if (roll < 98) op = clir_pkg::OP_REMOVE;
            else op = OP_UNUSED;
         end
         MODE_DRAIN: begin
            if (roll < 8) op = clir_pkg::OP_APPEND;
            else if (roll < 16) op = clir_pkg::OP_PREPEND;
            else if (roll < 98) op = clir_pkg::OP_REMOVE;
            else op = OP_UNUSED;
         end
         default: begin
            if (roll < 30) op = clir_pkg::OP_APPEND;
            else if (roll < 60) op = clir_pkg::OP_PREPEND;
            else if (roll < 97) op = clir_pkg::OP_REMOVE;
            else op = OP_UNUSED;
         end
      endcase
      // draw most remove keys from values that were sent, so removes hit
      if (op == clir_pkg::OP_REMOVE && sent_values.size() > 0
          && $urandom_range(0, 9) < 7) begin
         pick = $urandom_range(0, sent_values.size() - 1);
         v = sent_values[pick];
         sent_values.delete(pick);
      end else begin
         v = pick_value();
      end
      if ((op == clir_pkg::OP_APPEND || op == clir_pkg::OP_PREPEND)
          && sent_values.size() < CAPACITY)
         sent_values.push_back(v);
      issue_request(op, v);
   endtask

   initial begin
      int               sent;
      int               phase_len;
      traffic_mode_type mode;

      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= clir_pkg::OP_APPEND;
      req_value     <= '0;
      burst_left    = 0;
      for (int i = 0; i < 4; i++) op_tally[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, single entry, extremes, duplicates, miss, unused op
      issue_request(clir_pkg::OP_REMOVE,  32'sd0);
      issue_request(OP_UNUSED,            32'sd7);
      issue_request(clir_pkg::OP_APPEND,  32'sh7FFF_FFFF);
      issue_request(clir_pkg::OP_REMOVE,  32'sh7FFF_FFFF);
      issue_request(clir_pkg::OP_PREPEND, 32'sh8000_0000);
      issue_request(clir_pkg::OP_APPEND,  32'sd0);
      issue_request(clir_pkg::OP_APPEND,  -32'sd1);
      issue_request(clir_pkg::OP_PREPEND, 32'sd5);
      issue_request(clir_pkg::OP_APPEND,  32'sd5);
      issue_request(OP_UNUSED,            -32'sd1);
      issue_request(clir_pkg::OP_REMOVE,  32'sd12345);
      issue_request(clir_pkg::OP_REMOVE,  32'sd5);
      issue_request(clir_pkg::OP_REMOVE,  -32'sd1);
      issue_request(clir_pkg::OP_REMOVE,  32'sh8000_0000);
      issue_request(clir_pkg::OP_REMOVE,  32'sd5);
      issue_request(clir_pkg::OP_REMOVE,  32'sd5);
      issue_request(clir_pkg::OP_REMOVE,  32'sd0);
      issue_request(clir_pkg::OP_REMOVE,  32'sd0);
      issue_request(clir_pkg::OP_APPEND,  32'sh5555_5555);
      issue_request(clir_pkg::OP_PREPEND, 32'shAAAA_AAAA);
      issue_request(clir_pkg::OP_REMOVE,  32'shAAAA_AAAA);
      issue_request(clir_pkg::OP_REMOVE,  32'sh5555_5555);

      // open with a long fill so the store reaches full early
      sent = 0;
      sent_values.delete();
      for (int i = 0; i < CAPACITY + 8; i++) begin
         issue_request(($urandom_range(0, 1) == 0) ? clir_pkg::OP_APPEND
                                                   : clir_pkg::OP_PREPEND,
                       pick_value());
         sent++;
      end

      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: mode = MODE_FILL;
            1: mode = MODE_DRAIN;
            default: mode = MODE_MIXED;
         endcase
         phase_len = $urandom_range(20, 90);
         for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
            issue_random(mode);
            sent++;
         end
      end

      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (2 * CAPACITY + 8) @(posedge clock);

      $display("sent %0d appends, %0d prepends, %0d removes, %0d unused-selector requests",
               op_tally[clir_pkg::OP_APPEND], op_tally[clir_pkg::OP_PREPEND],
               op_tally[clir_pkg::OP_REMOVE], op_tally[OP_UNUSED]);
      $display("checked %0d results: %0d full, %0d empty, %0d key misses",
               results_checked, full_seen, empty_seen, miss_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
